FILE: design/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared constants, codes and types of the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // screen geometry
  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int TAB_STOP     = 8;
  localparam int CELL_COUNT   = ROWS * COLUMNS;
  localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;

  // field widths of the request and result items
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;
  localparam int LIN_W    = 11;
  localparam int CELL_W   = 16;
  localparam int CHAR_W   = 8;

  // screen store addressing
  localparam int ADDR_W    = $clog2(CELL_COUNT);
  localparam int COL_IDX_W = $clog2(COLUMNS);

  // configuration registers
  localparam int TEXT_W     = 4;
  localparam int BACK_W     = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_TEXT = 1'b0;
  localparam logic REG_BACK = 1'b1;

  // reset values
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;
  localparam logic [ROW_W-1:0]  RESET_ROW  = 5'd23;
  localparam logic [TEXT_W-1:0] RESET_TEXT = 4'd15;
  localparam logic [BACK_W-1:0] RESET_BACK = 3'd0;

  // request kinds
  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // byte codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] PRINT_LO = 8'd32;
  localparam logic [CHAR_W-1:0] PRINT_HI = 8'd126;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FILL  = 5'b00010,
    ST_COPY  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

  // next tab column for every cursor column
  typedef logic [COL_W-1:0] tab_lut_t [COLUMNS];

  function automatic tab_lut_t build_tab_lut();
    tab_lut_t t;
    int       nxt;
    for (int i = 0; i < COLUMNS; i++) begin
      nxt  = (i / TAB_STOP + 1) * TAB_STOP;
      t[i] = COL_W'((nxt < COLUMNS) ? nxt : COLUMNS - 1);
    end
    return t;
  endfunction

  localparam tab_lut_t TAB_LUT = build_tab_lut();

endpackage

FILE: design/tcce_in_if.sv
// ----------------------------------------------------------------------------
// tcce_in_if
// Request channel: one byte to process or one screen cell to read.
// ----------------------------------------------------------------------------
interface tcce_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [tcce_pkg::CHAR_W-1:0]   char_code;
  logic                          end_of_string;
  logic [tcce_pkg::ROW_W-1:0]    read_row;
  logic [tcce_pkg::COL_W-1:0]    read_column;

  modport source (
    output valid, func, char_code, end_of_string, read_row, read_column,
    input  ready
  );

  modport sink (
    input  valid, func, char_code, end_of_string, read_row, read_column,
    output ready
  );
endinterface

FILE: design/tcce_out_if.sv
// ----------------------------------------------------------------------------
// tcce_out_if
// Result channel: cursor position after a request and the cell read.
// ----------------------------------------------------------------------------
interface tcce_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcce_pkg::ROW_W-1:0]    cursor_row_out;
  logic [tcce_pkg::COL_W-1:0]    cursor_column_out;
  logic [tcce_pkg::LIN_W-1:0]    cursor_linear;
  logic [tcce_pkg::CELL_W-1:0]   cell_data;

  modport source (
    output valid, cursor_row_out, cursor_column_out, cursor_linear, cell_data,
    input  ready
  );

  modport sink (
    input  valid, cursor_row_out, cursor_column_out, cursor_linear, cell_data,
    output ready
  );
endinterface

FILE: design/tcce_ram.sv
// ----------------------------------------------------------------------------
// tcce_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/text_console_character_engine.sv
// ----------------------------------------------------------------------------
// text_console_character_engine
// Text console with an 80x25 screen store of 16-bit cells and a cursor.
// ----------------------------------------------------------------------------
// The screen lives in one 2000 x 16 single-write, single-read RAM and the
// cursor in registers. One request is handled at a time. A printable byte
// or a cursor control byte that neither scrolls nor clears, or a cell read,
// issues its RAM write or read in the accept cycle and then goes on to the
// result. A byte that scrolls runs a copy sweep through the RAM read/write
// ports followed by blanking of the last row; a pending wrap on the last row
// followed by a line feed scrolls twice. A form feed blanks the whole store.
// After reset a clearing pass fills the store with blanks before the first
// request is accepted; configuration writes are taken at any time. A finished
// result sits in an output register while the next request is accepted.
// ----------------------------------------------------------------------------
module text_console_character_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  tcce_in_if.sink                             in_ch,
  tcce_out_if.source                          out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [tcce_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [tcce_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int ADDR_W = tcce_pkg::ADDR_W;
  localparam int ROW_W  = tcce_pkg::ROW_W;
  localparam int COL_W  = tcce_pkg::COL_W;
  localparam int LIN_W  = tcce_pkg::LIN_W;
  localparam int CELL_W = tcce_pkg::CELL_W;

  // sequencer and cursor state
  tcce_pkg::state_t       state_r, state_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [COL_W-1:0]       col_r, col_nxt;
  logic [ADDR_W-1:0]      cnt_r, cnt_nxt;
  logic [1:0]             scroll_r, scroll_nxt;
  logic                   wr_pend_r, wr_pend_nxt;
  logic                   act_r, act_nxt;
  logic                   is_read_r, is_read_nxt;
  logic                   rd_ok_r, rd_ok_nxt;
  logic [ADDR_W-1:0]      wr_addr_r, wr_addr_nxt;
  logic [CELL_W-1:0]      wr_data_r, wr_data_nxt;

  // configuration
  logic [tcce_pkg::TEXT_W-1:0] text_r;
  logic [tcce_pkg::BACK_W-1:0] back_r;

  // result register
  logic                   out_valid_r;
  logic [ROW_W-1:0]       out_row_r;
  logic [COL_W-1:0]       out_col_r;
  logic [LIN_W-1:0]       out_lin_r;
  logic [CELL_W-1:0]      out_cell_r;
  logic                   load_out;

  // RAM ports
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [CELL_W-1:0]      ram_wdata;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [CELL_W-1:0]      ram_rdata;

  // byte decode
  logic                   in_acc;
  logic                   wrap, last_row, sc1, sc2, printable, rd_ok;
  logic [ROW_W-1:0]       row1, row2;
  logic [COL_W-1:0]       col1, col2;
  logic [1:0]             scnt;
  logic [ADDR_W-1:0]      wr_lin, rd_lin;
  logic [CELL_W-1:0]      new_cell;

  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (tcce_pkg::CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == tcce_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // resolve pending wrap, then apply the byte to the cursor
  always_comb begin
    wrap      = (col_r == COL_W'(tcce_pkg::COLUMNS));
    last_row  = (row_r == ROW_W'(tcce_pkg::ROWS - 1));
    sc1       = wrap && last_row;
    row1      = (wrap && !last_row) ? row_r + 1'b1 : row_r;
    col1      = wrap ? '0 : col_r;
    printable = (in_ch.char_code >= tcce_pkg::PRINT_LO) &&
                (in_ch.char_code <= tcce_pkg::PRINT_HI);
    row2      = row1;
    col2      = col1;
    sc2       = 1'b0;
    case (in_ch.char_code)
      tcce_pkg::CH_BS: begin
        col2 = (col1 == '0) ? col1 : col1 - 1'b1;
      end
      tcce_pkg::CH_TAB: begin
        col2 = tcce_pkg::TAB_LUT[col1[tcce_pkg::COL_IDX_W-1:0]];
      end
      tcce_pkg::CH_LF: begin
        col2 = '0;
        if (row1 == ROW_W'(tcce_pkg::ROWS - 1)) begin
          sc2 = 1'b1;
        end else begin
          row2 = row1 + 1'b1;
        end
      end
      tcce_pkg::CH_FF: begin
        row2 = '0;
        col2 = '0;
      end
      tcce_pkg::CH_CR: begin
        col2 = '0;
      end
      default: begin
        if (printable) begin
          col2 = col1 + 1'b1;
        end
      end
    endcase
    scnt     = {1'b0, sc1} + {1'b0, sc2};
    wr_lin   = ADDR_W'(ADDR_W'(row1) * ADDR_W'(tcce_pkg::COLUMNS)) + ADDR_W'(col1);
    new_cell = {1'b0, back_r, text_r, in_ch.char_code};
    rd_ok    = (int'(in_ch.read_row) < tcce_pkg::ROWS) &&
               (int'(in_ch.read_column) < tcce_pkg::COLUMNS);
    rd_lin   = ADDR_W'(ADDR_W'(in_ch.read_row) * ADDR_W'(tcce_pkg::COLUMNS)) +
               ADDR_W'(in_ch.read_column);
  end

  assign load_out = (state_r == tcce_pkg::ST_RESP) && (!out_valid_r || out_ch.ready);

  // sequencer: accept, scroll copy, blank fill, deferred write, result
  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    cnt_nxt     = cnt_r;
    scroll_nxt  = scroll_r;
    wr_pend_nxt = wr_pend_r;
    act_nxt     = act_r;
    is_read_nxt = is_read_r;
    rd_ok_nxt   = rd_ok_r;
    wr_addr_nxt = wr_addr_r;
    wr_data_nxt = wr_data_r;
    ram_we      = 1'b0;
    ram_waddr   = cnt_r;
    ram_wdata   = tcce_pkg::BLANK_CELL;
    ram_re      = 1'b0;
    ram_raddr   = rd_lin;
    case (state_r)
      tcce_pkg::ST_IDLE: begin
        if (in_acc) begin
          act_nxt     = 1'b1;
          is_read_nxt = (in_ch.func == tcce_pkg::FUNC_READ);
          rd_ok_nxt   = rd_ok;
          if (in_ch.func == tcce_pkg::FUNC_READ) begin
            ram_re    = rd_ok;
            state_nxt = tcce_pkg::ST_RESP;
          end else begin
            row_nxt = row2;
            col_nxt = col2;
            if (in_ch.char_code == tcce_pkg::CH_FF) begin
              cnt_nxt     = '0;
              scroll_nxt  = '0;
              wr_pend_nxt = 1'b0;
              state_nxt   = tcce_pkg::ST_FILL;
            end else if (scnt != '0) begin
              scroll_nxt  = scnt;
              cnt_nxt     = '0;
              wr_pend_nxt = printable;
              wr_addr_nxt = wr_lin;
              wr_data_nxt = new_cell;
              state_nxt   = tcce_pkg::ST_COPY;
            end else begin
              ram_we    = printable;
              ram_waddr = wr_lin;
              ram_wdata = new_cell;
              state_nxt = tcce_pkg::ST_RESP;
            end
          end
        end
      end
      tcce_pkg::ST_COPY: begin
        // read a cell one row down, write the previous one a row up
        ram_re    = (cnt_r < ADDR_W'(tcce_pkg::SCROLL_CELLS));
        ram_raddr = cnt_r + ADDR_W'(tcce_pkg::COLUMNS);
        ram_we    = (cnt_r != '0);
        ram_waddr = cnt_r - 1'b1;
        ram_wdata = ram_rdata;
        if (cnt_r == ADDR_W'(tcce_pkg::SCROLL_CELLS)) begin
          scroll_nxt = scroll_r - 1'b1;
          state_nxt  = tcce_pkg::ST_FILL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tcce_pkg::ST_FILL: begin
        ram_we = 1'b1;
        if (cnt_r == ADDR_W'(tcce_pkg::CELL_COUNT - 1)) begin
          if (scroll_r != '0) begin
            cnt_nxt   = '0;
            state_nxt = tcce_pkg::ST_COPY;
          end else if (wr_pend_r) begin
            state_nxt = tcce_pkg::ST_WRITE;
          end else if (act_r) begin
            state_nxt = tcce_pkg::ST_RESP;
          end else begin
            state_nxt = tcce_pkg::ST_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tcce_pkg::ST_WRITE: begin
        ram_we      = 1'b1;
        ram_waddr   = wr_addr_r;
        ram_wdata   = wr_data_r;
        wr_pend_nxt = 1'b0;
        state_nxt   = tcce_pkg::ST_RESP;
      end
      tcce_pkg::ST_RESP: begin
        if (load_out) begin
          act_nxt   = 1'b0;
          state_nxt = tcce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcce_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcce_pkg::ST_FILL;
      row_r       <= tcce_pkg::RESET_ROW;
      col_r       <= '0;
      cnt_r       <= '0;
      scroll_r    <= '0;
      wr_pend_r   <= 1'b0;
      act_r       <= 1'b0;
      is_read_r   <= 1'b0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      cnt_r     <= cnt_nxt;
      scroll_r  <= scroll_nxt;
      wr_pend_r <= wr_pend_nxt;
      act_r     <= act_nxt;
      is_read_r <= is_read_nxt;
      rd_ok_r   <= rd_ok_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // deferred write and result payload
  always_ff @(posedge clk) begin
    wr_addr_r <= wr_addr_nxt;
    wr_data_r <= wr_data_nxt;
    if (load_out) begin
      out_row_r  <= row_r;
      out_col_r  <= col_r;
      out_lin_r  <= LIN_W'(LIN_W'(row_r) * LIN_W'(tcce_pkg::COLUMNS)) + LIN_W'(col_r);
      out_cell_r <= (is_read_r && rd_ok_r) ? ram_rdata : '0;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.cursor_row_out    = out_row_r;
  assign out_ch.cursor_column_out = out_col_r;
  assign out_ch.cursor_linear     = out_lin_r;
  assign out_ch.cell_data         = out_cell_r;

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_r <= tcce_pkg::RESET_TEXT;
      back_r <= tcce_pkg::RESET_BACK;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == tcce_pkg::REG_TEXT) begin
        text_r <= cfg_pwdata[tcce_pkg::TEXT_W-1:0];
      end else begin
        back_r <= cfg_pwdata[tcce_pkg::BACK_W-1:0];
      end
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == tcce_pkg::REG_BACK) ?
                      tcce_pkg::CFG_DATA_W'(back_r) : tcce_pkg::CFG_DATA_W'(text_r);

  // checks
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROW_W'(tcce_pkg::ROWS - 1))
    else $error("cursor row beyond last row");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(tcce_pkg::COLUMNS))
    else $error("cursor column beyond pending wrap");

  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("screen read and write hit the same cell");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != tcce_pkg::ST_IDLE))
    else $error("request accepted without leaving idle");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcce_pkg::ST_RESP && out_valid_r && !out_ch.ready) |=>
    (state_r == tcce_pkg::ST_RESP))
    else $error("result dropped while output register full");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and checking for the text console character engine. A short list
// of directed requests walks through reads, the control bytes, scrolling and
// the pending wrap. Random text with control bytes and cell reads follows
// under several colour settings and handshake idling patterns. Each result
// is held to a set expectation or a cycle-free model of screen and cursor.
// ----------------------------------------------------------------------------
module tb_top;
  import tcce_pkg::*;

  // a double scroll per request is the slowest the block can be; wide margin
  localparam int unsigned CYCLE_LIMIT     = 20_000_000;
  localparam int          ITEMS_PER_PHASE = 175;
  localparam int          PHASES          = 4;
  localparam int          SETTLE_CYCLES   = 20;
  localparam int          REPORT_MAX      = 10;

  localparam logic [CFG_ADDR_W-1:0] TEXT_ADDR = {REG_TEXT, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] BACK_ADDR = {REG_BACK, 2'b00};

  typedef struct packed {
    logic              func;
    logic [CHAR_W-1:0] char_code;
    logic              eos;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_column;
  } request_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [LIN_W-1:0]  lin;
    logic [CELL_W-1:0] cdata;
  } report_t;

  typedef struct {
    request_t req;
    int       reps;
    bit       typed;
    report_t  want;
  } step_t;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  logic                  take_report = 1'b0;

  int unsigned cycle_count = 0;
  int unsigned failures    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  // console model: screen, cursor and colours
  logic [CELL_W-1:0] screen_model [CELL_COUNT];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [TEXT_W-1:0] fg_colour;
  logic [BACK_W-1:0] bg_colour;

  report_t reports_due [$];
  step_t   directed_steps [$];

  tcce_in_if  req_ch ();
  tcce_out_if res_ch ();

  assign res_ch.ready = take_report;

  text_console_character_engine dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (req_ch),
    .out_ch      (res_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("text_console_character_engine test failed");
    $finish;
  end

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------- model

  function automatic void clear_screen();
    for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = BLANK_CELL;
  endfunction

  function automatic void next_line();
    if (cur_row >= ROWS - 1) begin
      // scroll up one row, last row blank
      for (int i = 0; i < SCROLL_CELLS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = SCROLL_CELLS; i < CELL_COUNT; i++) screen_model[i] = BLANK_CELL;
      cur_row = ROWS - 1;
    end else begin
      cur_row++;
    end
    cur_col = 0;
  endfunction

  function automatic report_t apply_console_request(request_t r);
    report_t     res;
    int unsigned tab_col;
    res.cdata = '0;
    if (r.func == FUNC_CHAR) begin
      // pending wrap is resolved before any byte
      if (cur_col >= COLUMNS) next_line();
      if (r.char_code >= PRINT_LO && r.char_code <= PRINT_HI) begin
        screen_model[cur_row * COLUMNS + cur_col] = {1'b0, bg_colour, fg_colour, r.char_code};
        cur_col++;
      end else begin
        case (r.char_code)
          CH_BS: begin
            if (cur_col != 0) cur_col--;
          end
          CH_TAB: begin
            tab_col = (cur_col / TAB_STOP + 1) * TAB_STOP;
            cur_col = (tab_col < COLUMNS) ? tab_col : COLUMNS - 1;
          end
          CH_LF: next_line();
          CH_FF: begin
            clear_screen();
            cur_row = 0;
            cur_col = 0;
          end
          CH_CR: cur_col = 0;
          default: ;
        endcase
      end
    end else if (r.read_row < ROWS && r.read_column < COLUMNS) begin
      res.cdata = screen_model[r.read_row * COLUMNS + r.read_column];
    end
    res.row = ROW_W'(cur_row);
    res.col = COL_W'(cur_col);
    res.lin = LIN_W'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  // ------------------------------------------------------------ request side

  // called at a rising edge; valid is still high after the previous request
  task automatic push_request(input request_t r, input bit typed, input report_t want);
    int      gap;
    report_t predicted;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.func          <= r.func;
    req_ch.char_code     <= r.char_code;
    req_ch.end_of_string <= r.eos;
    req_ch.read_row      <= r.read_row;
    req_ch.read_column   <= r.read_column;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_console_request(r);
    reports_due.push_back(typed ? want : predicted);
  endtask

  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    r.func        = FUNC_CHAR;
    r.char_code   = CHAR_W'($urandom);
    r.eos         = 1'($urandom);
    r.read_row    = ROW_W'($urandom);
    r.read_column = COL_W'($urandom);
    pick = $urandom_range(999);
    if (pick < 180) begin
      r.func = FUNC_READ;
      // mostly cells on screen, some anywhere in the field range
      if ($urandom_range(9) != 0) begin
        r.read_row    = ROW_W'($urandom_range(ROWS - 1));
        r.read_column = COL_W'($urandom_range(COLUMNS - 1));
      end
    end else if (pick < 700) r.char_code = CHAR_W'($urandom_range(PRINT_HI, PRINT_LO));
    else if (pick < 750) r.char_code = CH_BS;
    else if (pick < 800) r.char_code = CH_TAB;
    else if (pick < 840) r.char_code = CH_CR;
    else if (pick < 940) r.char_code = CH_LF;
    else if (pick < 943) r.char_code = CH_FF;
    return r;
  endfunction

  function automatic void add_step(logic f, logic [CHAR_W-1:0] code, logic eos, int rr, int rc,
                                   int reps, bit typed, int er, int ec, int el, int ecell);
    step_t s;
    s.req   = '{func: f, char_code: code, eos: eos, read_row: ROW_W'(rr),
                read_column: COL_W'(rc)};
    s.reps  = reps;
    s.typed = typed;
    s.want  = '{row: ROW_W'(er), col: COL_W'(ec), lin: LIN_W'(el), cdata: CELL_W'(ecell)};
    directed_steps.push_back(s);
  endfunction

  // ------------------------------------------------------ configuration port

  // called at a rising edge, returns at a rising edge with the port idle
  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_colours();
    logic [CFG_DATA_W-1:0] rd;
    cfg_access(1'b0, TEXT_ADDR, '0, rd);
    if (rd !== CFG_DATA_W'(fg_colour))
      note_failure($sformatf("text colour readback: expected %0d got %0h", fg_colour, rd));
    cfg_access(1'b0, BACK_ADDR, '0, rd);
    if (rd !== CFG_DATA_W'(bg_colour))
      note_failure($sformatf("background readback: expected %0d got %0h", bg_colour, rd));
  endtask

  task automatic set_colours(input logic [TEXT_W-1:0] fg, input logic [BACK_W-1:0] bg);
    logic [CFG_DATA_W-1:0] wd;
    logic [CFG_DATA_W-1:0] rd;
    // junk in the upper bits, only the register width is kept
    wd = $urandom;
    wd[TEXT_W-1:0] = fg;
    cfg_access(1'b1, TEXT_ADDR, wd, rd);
    wd = $urandom;
    wd[BACK_W-1:0] = bg;
    cfg_access(1'b1, BACK_ADDR, wd, rd);
    fg_colour = fg;
    bg_colour = bg;
    check_colours();
  endtask

  // ------------------------------------------------------------- result side

  always @(posedge clk) take_report <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    report_t seen;
    report_t due;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      seen = {res_ch.cursor_row_out, res_ch.cursor_column_out, res_ch.cursor_linear,
              res_ch.cell_data};
      if (reports_due.size() == 0) begin
        note_failure($sformatf("unexpected report row %0d col %0d lin %0d cell %h",
                               seen.row, seen.col, seen.lin, seen.cdata));
      end else begin
        due = reports_due.pop_front();
        if (seen !== due)
          note_failure($sformatf({"report mismatch: expected row %0d col %0d lin %0d cell %h,",
                                  " got row %0d col %0d lin %0d cell %h"},
                                 due.row, due.col, due.lin, due.cdata,
                                 seen.row, seen.col, seen.lin, seen.cdata));
      end
    end
  end

  // ------------------------------------------------------------------- main

  initial begin
    logic [TEXT_W-1:0] fg;
    logic [BACK_W-1:0] bg;
    rst_n                = 1'b0;
    cfg_psel             = 1'b0;
    cfg_penable          = 1'b0;
    cfg_pwrite           = 1'b0;
    cfg_paddr            = '0;
    cfg_pwdata           = '0;
    req_ch.valid         = 1'b0;
    req_ch.func          = FUNC_CHAR;
    req_ch.char_code     = '0;
    req_ch.end_of_string = 1'b0;
    req_ch.read_row      = '0;
    req_ch.read_column   = '0;

    clear_screen();
    cur_row   = 32'(RESET_ROW);
    cur_col   = 0;
    fg_colour = RESET_TEXT;
    bg_colour = RESET_BACK;

    // directed steps, cursor starts at row 23 column 0, white on black
    add_step(FUNC_READ, '0, 1'b0, 0, 0, 1, 1'b1, 23, 0, 1840, int'(BLANK_CELL));
    // read outside the screen, every read field bit set
    add_step(FUNC_READ, 8'hFF, 1'b1, 31, 127, 1, 1'b1, 23, 0, 1840, 0);
    add_step(FUNC_READ, '0, 1'b0, 0, COLUMNS, 1, 1'b1, 23, 0, 1840, 0);
    // letter A with end of string and junk read fields
    add_step(FUNC_CHAR, 8'h41, 1'b1, 31, 127, 1, 1'b1, 23, 1, 1841, 0);
    add_step(FUNC_READ, '0, 1'b0, 23, 0, 1, 1'b1, 23, 1, 1841, 16'h0F41);
    add_step(FUNC_CHAR, PRINT_HI, 1'b0, 0, 0, 1, 1'b0, 0, 0, 0, 0);
    // bytes that do nothing, then a backspace and a carriage return
    add_step(FUNC_CHAR, 8'hFF, 1'b0, 0, 0, 1, 1'b0, 0, 0, 0, 0);
    add_step(FUNC_CHAR, 8'h00, 1'b0, 0, 0, 1, 1'b0, 0, 0, 0, 0);
    add_step(FUNC_CHAR, CH_BS, 1'b0, 0, 0, 1, 1'b0, 0, 0, 0, 0);
    add_step(FUNC_CHAR, CH_CR, 1'b0, 0, 0, 1, 1'b0, 0, 0, 0, 0);
    // down to the last row, then a scroll
    add_step(FUNC_CHAR, CH_LF, 1'b0, 0, 0, 2, 1'b0, 0, 0, 0, 0);
    // tabs up to the clamp at the last column
    add_step(FUNC_CHAR, CH_TAB, 1'b0, 0, 0, 10, 1'b0, 0, 0, 0, 0);
    // fills the last column, wrap now pending
    add_step(FUNC_CHAR, PRINT_LO + 8'd1, 1'b0, 0, 0, 1, 1'b0, 0, 0, 0, 0);
    // a read leaves the pending wrap alone
    add_step(FUNC_READ, '0, 1'b0, 22, 0, 1, 1'b0, 0, 0, 0, 0);
    // wrap on the last row scrolls, then the line feed scrolls again
    add_step(FUNC_CHAR, CH_LF, 1'b0, 0, 0, 1, 1'b0, 0, 0, 0, 0);
    add_step(FUNC_CHAR, CH_FF, 1'b0, 0, 0, 1, 1'b1, 0, 0, 0, 0);
    add_step(FUNC_READ, '0, 1'b0, ROWS - 1, COLUMNS - 1, 1, 1'b1, 0, 0, 0, int'(BLANK_CELL));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers come out of reset at white on black
    check_colours();

    foreach (directed_steps[i])
      repeat (directed_steps[i].reps)
        push_request(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].want);

    // random text under different colours and idling patterns
    for (int phase = 0; phase < PHASES; phase++) begin
      hold_until_drained();
      case (phase)
        0: begin
          fg = TEXT_W'(0); bg = BACK_W'(7); send_idle_pct = 0; stall_pct = 0;
        end
        1: begin
          fg = TEXT_W'(15); bg = BACK_W'(7); send_idle_pct = 57; stall_pct = 0;
        end
        2: begin
          fg = TEXT_W'(0); bg = BACK_W'(0); send_idle_pct = 0; stall_pct = 57;
        end
        default: begin
          fg = TEXT_W'($urandom); bg = BACK_W'($urandom); send_idle_pct = 18; stall_pct = 18;
        end
      endcase
      set_colours(fg, bg);
      repeat (ITEMS_PER_PHASE) begin
        // now and then let the block run completely dry
        if ($urandom_range(39) == 0) hold_until_drained();
        push_request(random_request(), 1'b0, '0);
      end
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("text_console_character_engine test passed");
    end else begin
      $display("text_console_character_engine test failed");
    end
    $finish;
  end

endmodule
